// File: rtl/core/afd_pkg.sv
// Shared types and constants of the affine matrix decomposition block.
// No dependencies; every other file of the block imports this package.
package afd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int DIV_W     = DW + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_W);
    localparam int SQRT_STEPS = DW;

    localparam logic [1:0] ROW_MOVE = 2'd3;

    typedef struct packed {
        logic signed [DW-1:0] row0_x;
        logic signed [DW-1:0] row0_y;
        logic signed [DW-1:0] row0_z;
        logic signed [DW-1:0] row1_x;
        logic signed [DW-1:0] row1_y;
        logic signed [DW-1:0] row1_z;
        logic signed [DW-1:0] row2_x;
        logic signed [DW-1:0] row2_y;
        logic signed [DW-1:0] row2_z;
        logic signed [DW-1:0] move_x;
        logic signed [DW-1:0] move_y;
        logic signed [DW-1:0] move_z;
    } afd_req_t;

    typedef struct packed {
        logic [1:0]           row_index;
        logic signed [DW-1:0] elem_x;
        logic signed [DW-1:0] elem_y;
        logic signed [DW-1:0] elem_z;
        logic [DW-1:0]        row_scale;
        logic                 zero_length;
        logic                 last;
    } afd_rsp_t;

    // One classified matrix: magnitude and sign per basis element.
    typedef struct packed {
        logic [2:0][2:0][DW-1:0] mag;
        logic [2:0][2:0]         neg;
        logic [2:0][DW-1:0]      move;
    } afd_ent_t;

    function automatic logic [DW-1:0] abs_val(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + {{(DW-1){1'b0}}, 1'b1}) : v;
    endfunction

endpackage

// File: rtl/core/afd_front.sv
// Front end: accept a matrix and split each basis element into sign and magnitude.
// Depends on afd_pkg.
module afd_front import afd_pkg::*;
(
    input  logic     req_valid,
    output logic     req_ready,
    input  afd_req_t req,
    input  logic     q_full,
    output logic     q_push,
    output afd_ent_t q_data
);
    logic [2:0][2:0][DW-1:0] raw;

    assign raw[0] = {req.row0_z, req.row0_y, req.row0_x};
    assign raw[1] = {req.row1_z, req.row1_y, req.row1_x};
    assign raw[2] = {req.row2_z, req.row2_y, req.row2_x};

    assign req_ready = !q_full;
    assign q_push    = req_valid && !q_full;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                q_data.mag[r][k] = abs_val(raw[r][k]);
                q_data.neg[r][k] = raw[r][k][DW-1];
            end
        end
        q_data.move = {req.move_z, req.move_y, req.move_x};
    end
endmodule

// File: rtl/core/afd_queue.sv
// Two-entry queue between front end and back end.
// Depends on afd_pkg.
module afd_queue import afd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  afd_ent_t wdata,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output afd_ent_t rdata
);
    afd_ent_t   mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: rtl/core/afd_back.sv
// Back end: per basis row square-accumulate, bit-serial square root, three
// bit-serial dividers, then the translation row. Depends on afd_pkg.
module afd_back import afd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_empty,
    input  afd_ent_t q_data,
    output logic     q_pop,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output afd_rsp_t rsp
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]       state_reg;
    logic [1:0]       row_reg;
    logic [CNT_W-1:0] cnt_reg;
    afd_ent_t         ent_reg;
    logic [2*DW-1:0]  prod_reg, sum_reg;
    logic [DW-1:0]    root_reg;
    logic [DW+1:0]    srem_reg;
    logic             zero_reg;
    logic [2:0][DW-1:0]    rem_reg;
    logic [2:0][DIV_W-1:0] quo_reg, dvd_reg;
    logic             rsp_valid_reg;
    afd_rsp_t         rsp_reg;

    logic [2:0][DW-1:0] cur_mag;
    logic [2:0]         cur_neg;
    logic [DW-1:0]      sq_op;
    logic [2*DW-1:0]    sum_next;
    logic [DW+1:0]      s_try, s_trial;
    logic [DW-1:0]      root_next;
    logic [DW+1:0]      srem_next;
    logic [2:0][DW:0]   d_try;
    logic [2:0][DW-1:0] elem;
    logic               out_free;

    assign cur_mag  = ent_reg.mag[row_reg];
    assign cur_neg  = ent_reg.neg[row_reg];
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        sq_op    = (cnt_reg[1:0] == 2'd3) ? '0 : cur_mag[cnt_reg[1:0]];
        sum_next = (cnt_reg == '0) ? '0 : sum_reg + prod_reg;
        s_try    = {srem_reg[DW-1:0], sum_reg[2*DW-1 -: 2]};
        s_trial  = {root_reg, 2'b01};
        if (s_try >= s_trial)
        begin
            srem_next = s_try - s_trial;
            root_next = {root_reg[DW-2:0], 1'b1};
        end
        else
        begin
            srem_next = s_try;
            root_next = {root_reg[DW-2:0], 1'b0};
        end
        for (int k = 0; k < 3; k++)
        begin
            d_try[k] = {rem_reg[k], dvd_reg[k][DIV_W-1]};
            // saturate the quotient, then apply the sign
            if (cur_neg[k])
            begin
                elem[k] = (quo_reg[k] > DIV_W'(64'h8000_0000)) ? 32'h8000_0000
                        : (~quo_reg[k][DW-1:0] + 32'd1);
            end
            else
            begin
                elem[k] = (quo_reg[k] > DIV_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                        : quo_reg[k][DW-1:0];
            end
            if (zero_reg)
            begin
                elem[k] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    ent_reg <= q_data;
                end
            end
            S_SQ:
            begin
                prod_reg <= sq_op * sq_op;
                sum_reg  <= sum_next;
                srem_reg <= '0;
                root_reg <= '0;
            end
            S_SQRT:
            begin
                sum_reg  <= {sum_reg[2*DW-3:0], 2'b00};
                srem_reg <= srem_next;
                root_reg <= root_next;
                zero_reg <= (root_next == '0);
                for (int k = 0; k < 3; k++)
                begin
                    rem_reg[k] <= '0;
                    quo_reg[k] <= '0;
                    dvd_reg[k] <= {cur_mag[k], {FRAC_BITS{1'b0}}};
                end
            end
            S_DIV:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (d_try[k] >= {1'b0, root_reg})
                    begin
                        rem_reg[k] <= DW'(d_try[k] - {1'b0, root_reg});
                        quo_reg[k] <= {quo_reg[k][DIV_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k] <= d_try[k][DW-1:0];
                        quo_reg[k] <= {quo_reg[k][DIV_W-2:0], 1'b0};
                    end
                    dvd_reg[k] <= {dvd_reg[k][DIV_W-2:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_EMIT && out_free)
        begin
            rsp_reg.row_index <= row_reg;
            if (row_reg == ROW_MOVE)
            begin
                rsp_reg.elem_x      <= ent_reg.move[0];
                rsp_reg.elem_y      <= ent_reg.move[1];
                rsp_reg.elem_z      <= ent_reg.move[2];
                rsp_reg.row_scale   <= '0;
                rsp_reg.zero_length <= 1'b0;
                rsp_reg.last        <= 1'b1;
            end
            else
            begin
                rsp_reg.elem_x      <= elem[0];
                rsp_reg.elem_y      <= elem[1];
                rsp_reg.elem_z      <= elem[2];
                rsp_reg.row_scale   <= root_reg;
                rsp_reg.zero_length <= zero_reg;
                rsp_reg.last        <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= 2'd0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_EMIT && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= S_SQ;
                        row_reg   <= 2'd0;
                        cnt_reg   <= '0;
                    end
                end
                S_SQ:
                begin
                    if (cnt_reg == CNT_W'(3))
                    begin
                        state_reg <= S_SQRT;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_SQRT:
                begin
                    if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (root_next == '0) ? S_EMIT : S_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == CNT_W'(DIV_W - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        if (row_reg == ROW_MOVE)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (row_reg == 2'd2)
                        begin
                            row_reg <= ROW_MOVE;
                        end
                        else
                        begin
                            row_reg   <= row_reg + 2'd1;
                            state_reg <= S_SQ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// File: rtl/core/affine_matrix_srt_decompose.sv
// Top level of the affine matrix scale/rotation/translation decomposition.
// Depends on afd_pkg, afd_front, afd_queue and afd_back.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one 4x3 Q16.16 matrix per
//   transaction. rsp channel (rsp_valid/rsp_ready/rsp) returns four
//   transactions per matrix: basis rows 0, 1, 2 (normalized elements, length
//   in row_scale, zero_length for an all-zero row), then the translation row
//   with last set.
// Timing:
//   Each basis row runs square-accumulate on one 32x32 multiplier, a
//   bit-serial square root and three parallel bit-serial dividers of
//   32 + FRAC_BITS quotient bits, then loads the output register; a
//   zero-length row skips the divide. The back end takes the next matrix
//   from the queue only after the translation row of the current one.
//   The divider and square-root iterations set the rate.
//   A two-entry queue lets the front end take two more matrices while the
//   back end works, so req_ready stays high until the queue is full.
// Reset: asynchronous, active low; drops all queued and in-flight matrices.
// Stall: when rsp_ready is low the result holds in the output register and
//   the back end waits in front of it; the queue then fills and drops req_ready.
module affine_matrix_srt_decompose import afd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  afd_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output afd_rsp_t rsp
);
    logic     q_full, q_empty, q_push, q_pop;
    afd_ent_t q_wdata, q_rdata;

    // classify incoming matrix into sign/magnitude form
    afd_front u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    // decouple acceptance from the long arithmetic
    afd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    // advance each basis row through square, root, divide (skipped for a zero-length row) and emit
    afd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );
endmodule

// File: rtl/core/afd_checker.sv
// Port-level checks for the decomposition block, bound to the top level.
// Depends on afd_pkg.
module afd_checker import afd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input afd_rsp_t rsp
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_move_row: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.row_index == ROW_MOVE |->
            rsp.last && rsp.row_scale == '0 && !rsp.zero_length)
        else $error("translation row malformed");

    a_last_only_move: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.last |-> rsp.row_index == ROW_MOVE)
        else $error("last on a basis row");

    a_zero_row: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.zero_length |->
            rsp.row_scale == '0 && rsp.elem_x == '0 && rsp.elem_y == '0
            && rsp.elem_z == '0)
        else $error("zero-length row with nonzero data");
endmodule

bind affine_matrix_srt_decompose afd_checker u_afd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
